>>> hw/rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 to code point decoder.
// Used by u8d_decode, u8d_emit and utf8_to_code_point_decoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

   localparam int unsigned CpWidth    = 21;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 3;

   localparam logic [CpWidth-1:0] Subst = 21'h00FFFD;

   // One input word: a raw byte and the end-of-stream mark.
   typedef struct packed {
      logic [ByteWidth-1:0] in_byte;
      logic                 last_byte;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               is_replacement;
      logic               run_end;
   } rsp_word_type;

   // Results caused by one byte: a run of substitutes, then an optional value.
   typedef struct packed {
      logic [CountWidth-1:0] reps;
      logic                  has_value;
      logic [CpWidth-1:0]    value;
   } job_type;

endpackage

`default_nettype wire

>>> hw/rtl/u8d_decode.sv
// Sequence decoder: holds the open sequence and turns each byte into a job.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire u8d_pkg::req_word_type word,
   output u8d_pkg::job_type           job
);

   logic [u8d_pkg::CpWidth-1:0] acc_ff, acc_in;
   logic [2:0]                  len_ff, len_in;
   logic [1:0]                  held_ff, held_in;

   logic [7:0]                  b;
   logic                        cont;
   logic                        seq_open;
   logic [u8d_pkg::CpWidth-1:0] acc_shift;
   logic [2:0]                  held_p1;
   logic                        complete;
   logic                        bad;
   logic                        lead_ascii;
   logic                        lead_invalid;
   logic [2:0]                  lead_len;
   logic [u8d_pkg::CpWidth-1:0] lead_payload;

   assign b         = word.in_byte;
   assign cont      = (b[7:6] == 2'b10);
   assign seq_open  = (len_ff != 3'd0);
   assign acc_shift = {acc_ff[u8d_pkg::CpWidth-7:0], b[5:0]};
   assign held_p1   = {1'b0, held_ff} + 3'd1;
   assign complete  = (held_p1 == len_ff);

   // Flag overlong forms, surrogates and values above the Unicode range
   assign bad = ((len_ff == 3'd2) && (acc_shift < 21'h000080)) ||
                ((len_ff == 3'd3) && (acc_shift < 21'h000800)) ||
                ((len_ff == 3'd4) && (acc_shift < 21'h010000)) ||
                (acc_shift > 21'h10FFFF) ||
                ((acc_shift >= 21'h00D800) && (acc_shift <= 21'h00DFFF));

   // Classify the byte as a lead
   always_comb begin
      lead_ascii   = 1'b0;
      lead_invalid = 1'b0;
      lead_len     = 3'd0;
      lead_payload = '0;
      if (b < 8'h80) begin
         lead_ascii = 1'b1;
      end else if (b inside {[8'hC2:8'hDF]}) begin
         lead_len     = 3'd2;
         lead_payload = {16'd0, b[4:0]};
      end else if (b inside {[8'hE0:8'hEF]}) begin
         lead_len     = 3'd3;
         lead_payload = {17'd0, b[3:0]};
      end else if (b inside {[8'hF0:8'hF4]}) begin
         lead_len     = 3'd4;
         lead_payload = {18'd0, b[2:0]};
      end else begin
         lead_invalid = 1'b1;
      end
   end

   // Build the job and the next sequence state
   always_comb begin
      job.reps      = 3'd0;
      job.has_value = 1'b0;
      job.value     = {13'd0, b};
      acc_in        = acc_ff;
      len_in        = len_ff;
      held_in       = held_ff;
      if (seq_open && cont) begin
         if (complete) begin
            acc_in  = '0;
            len_in  = 3'd0;
            held_in = 2'd0;
            if (bad) begin
               job.reps = held_p1;
            end else begin
               job.has_value = 1'b1;
               job.value     = acc_shift;
            end
         end else begin
            acc_in  = acc_shift;
            held_in = held_p1[1:0];
            // Truncated at stream end: flush every held byte
            if (word.last_byte) begin
               job.reps = held_p1;
               acc_in   = '0;
               len_in   = 3'd0;
               held_in  = 2'd0;
            end
         end
      end else begin
         // Drop a broken sequence, then rescan this byte as a lead
         job.reps = seq_open ? {1'b0, held_ff} : 3'd0;
         acc_in   = '0;
         len_in   = 3'd0;
         held_in  = 2'd0;
         if (lead_ascii) begin
            job.has_value = 1'b1;
         end else if (lead_invalid) begin
            job.reps = job.reps + 3'd1;
         end else if (word.last_byte) begin
            job.reps = job.reps + 3'd1;
         end else begin
            acc_in  = lead_payload;
            len_in  = lead_len;
            held_in = 2'd1;
         end
      end
   end

   // Advance the sequence state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         len_ff  <= 3'd0;
         held_ff <= 2'd0;
      end else if (accept) begin
         acc_ff  <= acc_in;
         len_ff  <= len_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/u8d_emit.sv
// Result sequencer: holds one job and drains it one word per cycle, while the
// output is not stalled, into the output register. Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire u8d_pkg::job_type      job_in,
   input  wire logic                  rsp_stall,
   output logic                       take_ok,
   output logic                       rsp_valid,
   output u8d_pkg::rsp_word_type      rsp_word
);

   logic [u8d_pkg::CountWidth-1:0] reps_ff, reps_in;
   logic                           has_value_ff, has_value_in;
   logic [u8d_pkg::CpWidth-1:0]    value_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   u8d_pkg::rsp_word_type          rsp_word_ff, rsp_word_in;

   logic out_free;
   logic pending;
   logic last_one;
   logic fire;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pending  = (reps_ff != '0) || has_value_ff;
   assign last_one = ((reps_ff == 3'd0) && has_value_ff) ||
                     ((reps_ff == 3'd1) && !has_value_ff);
   assign fire     = out_free && pending;
   assign take_ok  = !pending || (last_one && out_free);

   // Pick the next word: substitutes first, then the decoded value
   always_comb begin
      reps_in      = reps_ff;
      has_value_in = has_value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (reps_ff != '0) begin
            rsp_word_in.code_point     = u8d_pkg::Subst;
            rsp_word_in.is_replacement = 1'b1;
            rsp_word_in.run_end        = last_one;
            reps_in                    = reps_ff - 3'd1;
         end else begin
            rsp_word_in.code_point     = value_ff;
            rsp_word_in.is_replacement = 1'b0;
            rsp_word_in.run_end        = 1'b1;
            has_value_in               = 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold the job and the output word
   always_ff @(posedge clock) begin
      if (reset) begin
         reps_ff      <= '0;
         has_value_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            reps_ff      <= job_in.reps;
            has_value_ff <= job_in.has_value;
         end else begin
            reps_ff      <= reps_in;
            has_value_ff <= has_value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (load) begin
         value_ff <= job_in.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

>>> hw/rtl/utf8_to_code_point_decoder.sv
// UTF-8 to code point decoder, top level. Depends on u8d_pkg, u8d_decode, u8d_emit.
// Each result passes through the job register, then the output register. Throughput:
// one byte per cycle while each byte gives at most one word and rsp_stall is low; a
// byte giving more holds the input until its last word enters the one output register.
// Reset (synchronous, active high) closes any open sequence and empties the
// job and output registers.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_code_point_decoder (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire u8d_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output u8d_pkg::rsp_word_type      rsp_word
);

   logic             take_ok;
   logic             accept;
   u8d_pkg::job_type job;

   assign req_stall = !take_ok;
   assign accept    = req_valid && take_ok;

   // Decode the byte against the open sequence
   u8d_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .word   (req_word),
      .job    (job)
   );

   // Drain the job one word at a time
   u8d_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .job_in    (job),
      .rsp_stall (rsp_stall),
      .take_ok   (take_ok),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

>>> tb/tb_utf8_to_code_point_decoder.sv
// Self-checking testbench for utf8_to_code_point_decoder: directed table, then random UTF-8.
// Depends on u8d_pkg and the decoder RTL; every result word is checked by a built-in predictor.
`timescale 1ns / 1ps

module tb_utf8_to_code_point_decoder;

   import u8d_pkg::*;

   localparam int TotalItems    = 460;
   localparam int TailItems     = 40;
   localparam int HoldOffCycles = 80;
   localparam int HoldOffAt     = 150;
   localparam int CycleLimit    = 200000;
   localparam int NumDirRows    = 25;

   // One row of the directed table; cp is the last word's value when typed is set.
   typedef struct packed {
      logic [7:0]         in_byte;
      logic               last_byte;
      logic               typed;
      logic [CpWidth-1:0] cp;
   } dir_row_type;

   dir_row_type dir_rows [NumDirRows] = '{
      '{8'h00, 1'b0, 1'b1, 21'h000000},   // smallest ASCII
      '{8'h7F, 1'b0, 1'b1, 21'h00007F},   // largest ASCII
      '{8'h80, 1'b0, 1'b1, Subst},        // stray continuation as lead
      '{8'hC1, 1'b0, 1'b1, Subst},        // lead that can only be overlong
      '{8'hFF, 1'b0, 1'b1, Subst},        // never valid in UTF-8
      '{8'hC2, 1'b0, 1'b0, 21'h0},
      '{8'h80, 1'b0, 1'b1, 21'h000080},   // smallest two-byte value
      '{8'hF4, 1'b0, 1'b0, 21'h0},
      '{8'h8F, 1'b0, 1'b0, 21'h0},
      '{8'hBF, 1'b0, 1'b0, 21'h0},
      '{8'hBF, 1'b0, 1'b1, 21'h10FFFF},   // largest scalar value
      '{8'hE0, 1'b0, 1'b0, 21'h0},
      '{8'h80, 1'b0, 1'b0, 21'h0},
      '{8'h80, 1'b0, 1'b1, Subst},        // overlong three-byte form
      '{8'hED, 1'b0, 1'b0, 21'h0},
      '{8'hA0, 1'b0, 1'b0, 21'h0},
      '{8'h80, 1'b0, 1'b1, Subst},        // surrogate
      '{8'hF4, 1'b0, 1'b0, 21'h0},
      '{8'h90, 1'b0, 1'b0, 21'h0},
      '{8'h80, 1'b0, 1'b0, 21'h0},
      '{8'h80, 1'b0, 1'b1, Subst},        // above the Unicode range
      '{8'hE2, 1'b0, 1'b0, 21'h0},
      '{8'h41, 1'b0, 1'b1, 21'h000041},   // sequence broken by ASCII
      '{8'hF0, 1'b0, 1'b0, 21'h0},
      '{8'h90, 1'b1, 1'b1, Subst}         // truncated at stream end
   };

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   // Predictor state
   logic [CpWidth-1:0] acc_bits = '0;
   logic [2:0]         seq_len  = '0;
   logic [1:0]         held_cnt = '0;

   req_word_type byte_stream[$];
   rsp_word_type step_words[$];
   rsp_word_type expected_words[$];

   int  bytes_taken   = 0;
   int  words_checked = 0;
   int  subst_seen    = 0;
   int  errors        = 0;
   int  cycle_count   = 0;
   bit  tail_phase    = 1'b0;
   bit  hold_done     = 1'b0;

   utf8_to_code_point_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold reset, then release it on a falling edge
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void add_word(logic [CpWidth-1:0] cp, logic rep);
      rsp_word_type w;
      w.code_point     = cp;
      w.is_replacement = rep;
      w.run_end        = 1'b0;
      step_words.push_back(w);
   endfunction

   // Emit one substitute per held byte and close the open sequence
   function automatic void drop_sequence(int unsigned count);
      int unsigned k;
      for (k = 0; k < count; k++)
         add_word(Subst, 1'b1);
      acc_bits = '0;
      seq_len  = '0;
      held_cnt = '0;
   endfunction

   function automatic void open_lead(logic [7:0] b);
      if (b < 8'h80) begin
         add_word({13'b0, b}, 1'b0);
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         acc_bits = {16'b0, b[4:0]};
         seq_len  = 3'd2;
         held_cnt = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         acc_bits = {17'b0, b[3:0]};
         seq_len  = 3'd3;
         held_cnt = 2'd1;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         acc_bits = {18'b0, b[2:0]};
         seq_len  = 3'd4;
         held_cnt = 2'd1;
      end else begin
         add_word(Subst, 1'b1);
      end
   endfunction

   // Work out the words caused by one byte and queue them as expected
   function automatic void decode_step(req_word_type w);
      logic [7:0]         b;
      logic [CpWidth-1:0] cp;
      int unsigned        n_held;
      logic               bad;
      rsp_word_type       last_w;
      b = w.in_byte;
      step_words.delete();
      if (seq_len != 0) begin
         if (b[7:6] == 2'b10) begin
            n_held   = held_cnt + 1;
            acc_bits = {acc_bits[CpWidth-7:0], b[5:0]};
            if (n_held >= seq_len) begin
               cp  = acc_bits;
               bad = (seq_len == 3'd2 && cp < 21'h80) ||
                     (seq_len == 3'd3 && cp < 21'h800) ||
                     (seq_len == 3'd4 && cp < 21'h10000) ||
                     cp > 21'h10FFFF ||
                     (cp >= 21'hD800 && cp <= 21'hDFFF);
               if (bad) begin
                  drop_sequence(n_held);
               end else begin
                  add_word(cp, 1'b0);
                  drop_sequence(0);
               end
            end else begin
               held_cnt = n_held[1:0];
            end
         end else begin
            drop_sequence(held_cnt);
            open_lead(b);
         end
      end else begin
         open_lead(b);
      end
      if (w.last_byte && seq_len != 0)
         drop_sequence(held_cnt);
      // Mark the final word of this byte
      if (step_words.size() != 0) begin
         last_w = step_words.pop_back();
         last_w.run_end = 1'b1;
         step_words.push_back(last_w);
      end
      foreach (step_words[k])
         expected_words.push_back(step_words[k]);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void add_byte(logic [7:0] b, logic last);
      req_word_type w;
      w.in_byte   = b;
      w.last_byte = last;
      byte_stream.push_back(w);
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // Random scalar value whose encoding takes len bytes
   function automatic logic [CpWidth-1:0] pick_scalar(int len);
      logic [CpWidth-1:0] cp;
      case (len)
         1: cp = 21'($urandom_range(0, 'h7F));
         2: cp = 21'($urandom_range('h80, 'h7FF));
         3: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= 21'hD800 && cp <= 21'hDFFF)
               cp = cp ^ 21'h8000;
         end
         default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      return cp;
   endfunction

   function automatic void utf8_encode(input logic [CpWidth-1:0] cp, input int len,
                                       output logic [3:0][7:0] enc);
      enc = '0;
      case (len)
         1: enc[0] = cp[7:0];
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
   endfunction

   // Append one random group: mostly well-formed text, the rest noise and bad sequences
   function automatic void add_group();
      int              kind;
      int              len;
      int              n;
      int              k;
      logic [3:0][7:0] enc;
      logic [7:0]      b;
      kind = $urandom_range(0, 99);
      len  = (kind < 65) ? $urandom_range(1, 4) : $urandom_range(2, 4);
      utf8_encode(pick_scalar(len), len, enc);
      if (kind < 65) begin
         for (k = 0; k < len; k++)
            add_byte(enc[k], k == len - 1 && $urandom_range(0, 19) == 0);
      end else if (kind < 75) begin
         add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (kind < 85) begin
         // break an open sequence with a byte that is not a continuation
         n = $urandom_range(1, len - 1);
         for (k = 0; k < n; k++)
            add_byte(enc[k], 1'b0);
         b = 8'($urandom_range(0, 255));
         if (b[7:6] == 2'b10)
            b[6] = 1'b1;
         add_byte(b, 1'b0);
      end else if (kind < 93) begin
         // complete a sequence whose value is rejected
         case ($urandom_range(0, 3))
            0: begin
               add_byte(8'hE0, 1'b0);
               add_byte(8'h80 | 8'($urandom_range(0, 'h1F)), 1'b0);
            end
            1: begin
               add_byte(8'hED, 1'b0);
               add_byte(8'hA0 | 8'($urandom_range(0, 'h1F)), 1'b0);
            end
            2: begin
               add_byte(8'hF0, 1'b0);
               add_byte(8'h80 | 8'($urandom_range(0, 'h0F)), 1'b0);
               add_byte(cont_byte(), 1'b0);
            end
            default: begin
               add_byte(8'hF4, 1'b0);
               add_byte(8'h90 + 8'($urandom_range(0, 'h2F)), 1'b0);
               add_byte(cont_byte(), 1'b0);
            end
         endcase
         add_byte(cont_byte(), 1'b0);
      end else begin
         // end the stream inside a sequence
         n = $urandom_range(1, len - 1);
         for (k = 0; k < n; k++)
            add_byte(enc[k], k == n - 1);
      end
   endfunction

   // ---------------------------------------------------------------- input side

   initial begin : byte_sender
      int i;
      req_valid = 1'b0;
      req_word  = '0;
      foreach (dir_rows[r])
         add_byte(dir_rows[r].in_byte, dir_rows[r].last_byte);
      while (byte_stream.size() < TotalItems)
         add_group();
      wait (reset == 1'b0);
      for (i = 0; i < byte_stream.size(); i++) begin
         @(negedge clock);
         tail_phase = (i >= byte_stream.size() - TailItems);
         // idle in short bursts, with calm stretches
         if (!tail_phase && (i / 60) % 4 != 3 && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_word  <= byte_stream[i];
         do @(posedge clock); while (!(req_valid && !req_stall));
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then keep watching for stray words
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Decoded %0d bytes into %0d checked words, %0d of them substitutes.",
               bytes_taken, words_checked, subst_seen);
      $display("Output hold-off of %0d cycles applied: %0d; mismatches: %0d.",
               HoldOffCycles, hold_done, errors);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Predict on every accepted byte; check typed rows of the table
   always @(posedge clock) begin : byte_taker
      if (!reset && req_valid && !req_stall) begin
         decode_step(req_word);
         if (bytes_taken < NumDirRows && dir_rows[bytes_taken].typed) begin
            if (step_words.size() == 0 ||
                step_words[step_words.size() - 1].code_point != dir_rows[bytes_taken].cp) begin
               errors++;
               $display("%0t: table row %0d expected %h, got %h over %0d words", $time,
                        bytes_taken, dir_rows[bytes_taken].cp,
                        (step_words.size() != 0) ?
                           step_words[step_words.size() - 1].code_point : 21'h0,
                        step_words.size());
            end
         end
         bytes_taken++;
      end
   end

   // ---------------------------------------------------------------- output side

   initial begin : word_receiver
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         // one long hold-off so the block backs up into its input
         if (!hold_done && bytes_taken >= HoldOffAt) begin
            hold_done  = 1'b1;
            stall_left = HoldOffCycles;
         end else if (stall_left == 0 && !tail_phase && (bytes_taken / 50) % 4 != 2 &&
                      $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted word with the oldest expected word
   always @(posedge clock) begin : word_checker
      rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: word %h arrived with none expected", $time, rsp_word);
         end else begin
            exp_w = expected_words.pop_front();
            words_checked++;
            if (exp_w.is_replacement)
               subst_seen++;
            if (rsp_word.code_point != exp_w.code_point) begin
               errors++;
               $display("%0t: code_point expected %h, got %h", $time,
                        exp_w.code_point, rsp_word.code_point);
            end
            if (rsp_word.is_replacement != exp_w.is_replacement) begin
               errors++;
               $display("%0t: is_replacement expected %b, got %b", $time,
                        exp_w.is_replacement, rsp_word.is_replacement);
            end
            if (rsp_word.run_end != exp_w.run_end) begin
               errors++;
               $display("%0t: run_end expected %b, got %b", $time,
                        exp_w.run_end, rsp_word.run_end);
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timed out after %0d cycles, %0d words outstanding", $time,
                  CycleLimit, expected_words.size());
         $display("FAIL");
         $finish;
      end
   end

endmodule
